[rtl/shabsh_pkg.sv]
package shabsh_pkg;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        last_word;
	} digest_word_t;

	localparam int unsigned DIGEST_WORDS = 8;

	localparam logic [7:0] PAD_MARK    = 8'h80;
	localparam logic [5:0] LAST_POS    = 6'd63;
	localparam logic [5:0] LEN_POS     = 6'd56;
	localparam logic [5:0] PRE_LEN_POS = 6'd55;
	localparam logic [5:0] LAST_ROUND  = 6'd63;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		AFT_IDLE,
		AFT_MARK,
		AFT_ZERO,
		AFT_DONE
	} after_t;

	typedef enum logic [1:0] {
		SEL_MSG,
		SEL_MARK,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      shift_en;
		byte_sel_t byte_sel;
		logic      cap_len;
		logic      start_round;
		logic      round_en;
		logic      add_en;
		logic      restart;
		logic      load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] cnt;
		logic       rnd_last;
		logic       out_busy;
	} dp_sts_t;

endpackage

[rtl/shabsh_dp.sv]
module shabsh_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  shabsh_pkg::msg_word_t    msg,
	input  shabsh_pkg::dp_cmd_t      cmd,
	output shabsh_pkg::dp_sts_t      sts,
	output logic                     digest_valid,
	input  logic                     digest_stall,
	output shabsh_pkg::digest_word_t digest
);
	import shabsh_pkg::*;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	logic [511:0] blk_q;
	logic [5:0]   cnt_q;
	logic [63:0]  bits_q;
	logic [63:0]  len_q;
	logic [5:0]   rnd_q;
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [31:0]  out_q [DIGEST_WORDS];
	logic [3:0]   out_cnt_q;

	logic [7:0]  byte_in;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] s0, s1, bs0, bs1, ch, maj, t1, t2;
	logic        out_take;

	always_comb begin
		case (cmd.byte_sel)
			SEL_MSG:  byte_in = msg.msg_byte;
			SEL_MARK: byte_in = PAD_MARK;
			SEL_ZERO: byte_in = 8'h00;
			SEL_LEN:  byte_in = len_q[63:56];
			default:  byte_in = 8'h00;
		endcase
	end

	// message schedule window, word 0 at the top
	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];
	assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
	assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
	assign w_new = w0 + s0 + w9 + s1;

	assign bs1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
	assign bs0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + bs1 + ch + ROUND_K[rnd_q] + w0;
	assign t2  = bs0 + maj;

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.cap_len) begin
			len_q <= bits_q;
		end else if (cmd.shift_en && cmd.byte_sel == SEL_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (cmd.start_round) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			bits_q <= '0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
		end else begin
			if (cmd.restart) begin
				cnt_q  <= '0;
				bits_q <= '0;
				for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
			end else begin
				if (cmd.shift_en) begin
					cnt_q <= cnt_q + 6'd1;
				end
				if (cmd.shift_en && cmd.byte_sel == SEL_MSG) begin
					bits_q <= bits_q + 64'd8;
				end
				if (cmd.add_en) begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (cmd.start_round) begin
				rnd_q <= '0;
			end else if (cmd.round_en) begin
				rnd_q <= rnd_q + 6'd1;
			end
		end
	end

	// digest output stage, drains while the next message streams in
	assign out_take = digest_valid && !digest_stall;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			for (int i = 0; i < DIGEST_WORDS; i++) out_q[i] <= h_q[i];
		end else if (out_take) begin
			for (int i = 0; i < DIGEST_WORDS - 1; i++) out_q[i] <= out_q[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (cmd.load_out) begin
			out_cnt_q <= 4'(DIGEST_WORDS);
		end else if (out_take) begin
			out_cnt_q <= out_cnt_q - 4'd1;
		end
	end

	assign digest_valid       = out_cnt_q != 4'd0;
	assign digest.digest_word = out_q[0];
	assign digest.last_word   = out_cnt_q == 4'd1;

	assign sts.cnt      = cnt_q;
	assign sts.rnd_last = rnd_q == LAST_ROUND;
	assign sts.out_busy = out_cnt_q != 4'd0;

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_cnt_q == 4'd0)
		else $error("digest loaded over undelivered words");

	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en && !cmd.start_round |=> rnd_q == $past(rnd_q) + 6'd1)
		else $error("round counter did not advance");

	a_shift_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en |-> !cmd.shift_en && !cmd.add_en)
		else $error("round overlaps byte shift or hash add");

endmodule

[rtl/shabsh_ctrl.sv]
module shabsh_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	output logic                  msg_stall,
	input  shabsh_pkg::msg_word_t msg,
	input  shabsh_pkg::dp_sts_t   sts,
	output shabsh_pkg::dp_cmd_t   cmd
);
	import shabsh_pkg::*;

	state_t state_q, state_d;
	after_t aft_q, aft_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			aft_q   <= AFT_IDLE;
		end else begin
			state_q <= state_d;
			aft_q   <= aft_d;
		end
	end

	always_comb begin
		state_d = state_q;
		aft_d   = aft_q;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_valid) begin
					if (msg.has_byte && sts.cnt == LAST_POS) begin
						state_d = ST_ROUND;
						aft_d   = msg.end_of_message ? AFT_MARK : AFT_IDLE;
					end else if (msg.end_of_message) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_ROUND: begin
				if (sts.rnd_last) state_d = ST_ADD;
			end
			ST_ADD: begin
				unique case (aft_q)
					AFT_IDLE: state_d = ST_IDLE;
					AFT_MARK: state_d = ST_PAD_MARK;
					AFT_ZERO: state_d = ST_PAD_ZERO;
					AFT_DONE: state_d = ST_DONE;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_PAD_MARK: begin
				if (sts.cnt == LAST_POS) begin
					state_d = ST_ROUND;
					aft_d   = AFT_ZERO;
				end else if (sts.cnt == PRE_LEN_POS) begin
					state_d = ST_PAD_LEN;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (sts.cnt == LAST_POS) begin
					state_d = ST_ROUND;
					aft_d   = AFT_ZERO;
				end else if (sts.cnt == PRE_LEN_POS) begin
					state_d = ST_PAD_LEN;
				end
			end
			ST_PAD_LEN: begin
				if (sts.cnt == LAST_POS) begin
					state_d = ST_ROUND;
					aft_d   = AFT_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.byte_sel = SEL_MSG;
		msg_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				msg_stall = 1'b0;
				if (msg_valid && msg.has_byte) begin
					cmd.shift_en    = 1'b1;
					cmd.start_round = sts.cnt == LAST_POS;
				end
			end
			ST_ROUND: cmd.round_en = 1'b1;
			ST_ADD:   cmd.add_en = 1'b1;
			ST_PAD_MARK: begin
				cmd.shift_en    = 1'b1;
				cmd.byte_sel    = SEL_MARK;
				cmd.cap_len     = 1'b1;
				cmd.start_round = sts.cnt == LAST_POS;
			end
			ST_PAD_ZERO: begin
				cmd.shift_en    = 1'b1;
				cmd.byte_sel    = SEL_ZERO;
				cmd.start_round = sts.cnt == LAST_POS;
			end
			ST_PAD_LEN: begin
				cmd.shift_en    = 1'b1;
				cmd.byte_sel    = SEL_LEN;
				cmd.start_round = sts.cnt == LAST_POS;
			end
			ST_DONE: begin
				cmd.load_out = !sts.out_busy;
				cmd.restart  = !sts.out_busy;
			end
			default: ;
		endcase
	end

	a_final_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD_LEN && sts.cnt == LAST_POS
		|=> state_q == ST_ROUND && aft_q == AFT_DONE)
		else $error("length block not marked final");

	a_len_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_PAD_LEN ##1 state_q == ST_PAD_LEN |-> sts.cnt == LEN_POS)
		else $error("length bytes start at wrong position");

	a_round_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && !sts.rnd_last |=> state_q == ST_ROUND)
		else $error("compression left early");

endmodule

[rtl/sha256_byte_stream_hasher.sv]
// channel  dir  handshake                      payload
// msg      in   msg_valid / msg_stall          msg_byte, has_byte, end_of_message
// digest   out  digest_valid / digest_stall    digest_word, last_word
//
// a byte that does not complete a block is taken in idle without a stall
// a full block adds 64 rounds on the single round unit plus one hash add step
// end of message pads one byte per cycle outside compressions and runs one or two compressions
// the eight digest words drain from an output register while new bytes stream in
// arst_n clears control state and loads the initial hash values
module sha256_byte_stream_hasher (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     msg_valid,
	output logic                     msg_stall,
	input  shabsh_pkg::msg_word_t    msg,
	output logic                     digest_valid,
	input  logic                     digest_stall,
	output shabsh_pkg::digest_word_t digest
);
	import shabsh_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	shabsh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.sts       (sts),
		.cmd       (cmd)
	);

	shabsh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg          (msg),
		.cmd          (cmd),
		.sts          (sts),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

endmodule

[tb/sha256_digest_check.sv]
module sha256_digest_check (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     msg_valid,
	input  logic                     msg_stall,
	input  shabsh_pkg::msg_word_t    msg,
	input  logic                     digest_valid,
	input  logic                     digest_stall,
	input  shabsh_pkg::digest_word_t digest,
	output int                       words_outstanding,
	output int                       error_count
);

	import shabsh_pkg::*;

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE    = 8'h80;
	localparam int         LEN_OFFSET  = 56;
	localparam int         BLOCK_BYTES = 64;
	localparam int         HASH_WORDS  = 8;

	logic [31:0]  chain_value [HASH_WORDS];
	logic [7:0]   block_bytes [BLOCK_BYTES];
	int           block_fill;
	logic [63:0]  compressed_bits;
	digest_word_t expected_digest [$];

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hash_block();
		logic [31:0] sched [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			sched[i] = {block_bytes[4 * i], block_bytes[4 * i + 1],
				block_bytes[4 * i + 2], block_bytes[4 * i + 3]};
		for (i = 16; i < 64; i++) begin
			s0 = rotr(sched[i - 15], 7) ^ rotr(sched[i - 15], 18) ^ (sched[i - 15] >> 3);
			s1 = rotr(sched[i - 2], 17) ^ rotr(sched[i - 2], 19) ^ (sched[i - 2] >> 10);
			sched[i] = sched[i - 16] + s0 + sched[i - 7] + s1;
		end
		for (i = 0; i < 8; i++)
			v[i] = chain_value[i];
		for (i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + sched[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++)
			chain_value[i] = chain_value[i] + v[i];
	endfunction

	function automatic void restart_message();
		int k;
		for (k = 0; k < HASH_WORDS; k++)
			chain_value[k] = START_HASH[k];
		block_fill = 0;
		compressed_bits = '0;
	endfunction

	function automatic void absorb_word(input msg_word_t w);
		logic [63:0]  total;
		digest_word_t e;
		int pos;
		int k;
		if (w.has_byte) begin
			block_bytes[block_fill] = w.msg_byte;
			block_fill++;
			if (block_fill == BLOCK_BYTES) begin
				hash_block();
				compressed_bits = compressed_bits + 64'd512;
				block_fill = 0;
			end
		end
		if (w.end_of_message) begin
			total = compressed_bits + 64'(block_fill * 8);
			block_bytes[block_fill] = PAD_BYTE;
			pos = block_fill + 1;
			// no room left for the length field
			if (pos > LEN_OFFSET) begin
				while (pos < BLOCK_BYTES) begin
					block_bytes[pos] = '0;
					pos++;
				end
				hash_block();
				pos = 0;
			end
			while (pos < LEN_OFFSET) begin
				block_bytes[pos] = '0;
				pos++;
			end
			for (k = 0; k < 8; k++)
				block_bytes[BLOCK_BYTES - 1 - k] = total[8 * k +: 8];
			hash_block();
			for (k = 0; k < HASH_WORDS; k++) begin
				e.digest_word = chain_value[k];
				e.last_word = (k == HASH_WORDS - 1);
				expected_digest.push_back(e);
			end
			restart_message();
		end
	endfunction

	initial begin
		error_count = 0;
		words_outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		digest_word_t want;
		if (!arst_n) begin
			restart_message();
			expected_digest.delete();
		end else begin
			if (digest_valid && !digest_stall) begin
				if (expected_digest.size() == 0) begin
					$error("unexpected digest word: digest_word %h last_word %b",
						digest.digest_word, digest.last_word);
					error_count++;
				end else begin
					want = expected_digest.pop_front();
					if (digest.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, actual %h",
							want.digest_word, digest.digest_word);
						error_count++;
					end
					if (digest.last_word !== want.last_word) begin
						$error("last_word: expected %b, actual %b",
							want.last_word, digest.last_word);
						error_count++;
					end
				end
			end
			if (msg_valid && !msg_stall)
				absorb_word(msg);
		end
		words_outstanding = expected_digest.size();
	end

endmodule

[tb/testbench.sv]
module testbench;

	import shabsh_pkg::*;

	localparam int LONG_HOLD  = 400;
	localparam int DRAIN_WAIT = 200;
	localparam int RANDOM_ITEMS = 40;

	logic         clk;
	logic         arst_n;
	logic         msg_valid;
	logic         msg_stall;
	msg_word_t    msg;
	logic         digest_valid;
	logic         digest_stall;
	digest_word_t digest;
	int           words_outstanding;
	int           error_count;
	bit           quiet;
	bit           long_hold_req;
	int           items_sent;

	sha256_byte_stream_hasher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	sha256_digest_check digest_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.msg_valid         (msg_valid),
		.msg_stall         (msg_stall),
		.msg               (msg),
		.digest_valid      (digest_valid),
		.digest_stall      (digest_stall),
		.digest            (digest),
		.words_outstanding (words_outstanding),
		.error_count       (error_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#8000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_word(input logic [7:0] b, input logic has, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			msg_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg.msg_byte = b;
		msg.has_byte = has;
		msg.end_of_message = last;
		msg_valid = 1'b1;
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
		@(negedge clk);
		if (has || last)
			items_sent++;
	endtask

	// ignored words are sprinkled between the bytes
	task automatic send_message(input int len, input bit end_with_byte);
		int k;
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_word(8'($urandom_range(0, 255)), 1'b1, end_with_byte && k == len - 1);
		end
		if (len == 0 || !end_with_byte)
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic wait_drained();
		msg_valid = 1'b0;
		while (words_outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	initial begin : receiver
		int run;
		bit held;
		run = 0;
		held = 1'b0;
		digest_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !held) begin
				digest_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				held = 1'b1;
			end
			if (run > 0) begin
				digest_stall = 1'b1;
				run--;
			end else begin
				run = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
				digest_stall = (run > 0);
				if (run > 0)
					run--;
			end
		end
	end

	initial begin : stimulus
		int start;
		int r;
		int len;
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		quiet = 1'b1;
		long_hold_req = 1'b0;
		items_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty message, ignored words, single bytes ending the message, short multi-byte messages
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hff, 1'b0, 1'b0);
		send_word(8'h00, 1'b1, 1'b1);
		send_word(8'hff, 1'b1, 1'b1);
		send_word(8'h00, 1'b0, 1'b0);
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h62, 1'b1, 1'b0);
		send_word(8'h63, 1'b1, 1'b0);
		send_word(8'hff, 1'b0, 1'b1);
		send_word(8'hff, 1'b1, 1'b0);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'haa, 1'b1, 1'b0);
		send_word(8'h55, 1'b1, 1'b1);
		wait_drained();

		// padding around the length field and the block edge
		quiet = 1'b0;
		send_message(55, 1'($urandom_range(0, 1)));
		send_message(56, 1'($urandom_range(0, 1)));
		send_message(63, 1'($urandom_range(0, 1)));
		send_message(64, 1'b1);

		// receiver holds off while short messages pile up
		quiet = 1'b1;
		long_hold_req = 1'b1;
		repeat (6) send_message($urandom_range(0, 4), 1'($urandom_range(0, 1)));
		quiet = 1'b0;
		wait_drained();

		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				quiet = ~quiet;
			r = $urandom_range(0, 9);
			if (r < 6)
				len = $urandom_range(0, 8);
			else if (r < 9)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, 130);
			send_message(len, 1'($urandom_range(0, 1)));
		end
		quiet = 1'b0;
		wait_drained();

		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
